@@ rtl/accumulator_cpu_instruction_execute_top_assert.svh @@
// Assertion macros for the accumulator machine execute block.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef ACCUMULATOR_CPU_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define ACCUMULATOR_CPU_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/acie_pkg.sv @@
// Shared types, opcodes and status codes of the accumulator machine execute block.
// No dependencies; imported by every module of the block.
package acie_pkg;

    localparam int DATA_W          = 8;
    localparam int REG_COUNT_DEF   = 6;
    localparam int MEM_DEPTH_DEF   = 256;
    localparam int DIV_STEPS       = 8;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_AND  = 8'h01;
    localparam logic [7:0] OP_LDA  = 8'h02;
    localparam logic [7:0] OP_LDR  = 8'h03;
    localparam logic [7:0] OP_LDI  = 8'h04;
    localparam logic [7:0] OP_STA  = 8'h05;
    localparam logic [7:0] OP_STR  = 8'h06;
    localparam logic [7:0] OP_OR   = 8'h07;
    localparam logic [7:0] OP_XOR  = 8'h08;
    localparam logic [7:0] OP_SUB  = 8'h09;
    localparam logic [7:0] OP_ADD  = 8'h0A;
    localparam logic [7:0] OP_DIV  = 8'h0B;
    localparam logic [7:0] OP_MUL  = 8'h0C;
    localparam logic [7:0] OP_RSVD = 8'h0D;
    localparam logic [7:0] OP_NOT  = 8'h0E;
    localparam logic [7:0] OP_JMPR = 8'h0F;
    localparam logic [7:0] OP_JMP  = 8'h10;
    localparam logic [7:0] OP_RST  = 8'h11;
    localparam logic [7:0] OP_BEQ  = 8'h12;
    localparam logic [7:0] OP_BNE  = 8'h13;
    localparam logic [7:0] OP_BC   = 8'h14;
    localparam logic [7:0] OP_BNC  = 8'h15;
    localparam logic [7:0] OP_BGT  = 8'h16;
    localparam logic [7:0] OP_BLT  = 8'h17;
    localparam logic [7:0] OP_SETC = 8'h18;
    localparam logic [7:0] OP_CLRC = 8'h19;
    localparam logic [7:0] OP_NOPA = 8'h1A;
    localparam logic [7:0] OP_NOPB = 8'h1B;
    localparam logic [7:0] OP_HALT = 8'h1C;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_BADREG  = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [0:0] CFG_START_ADDR = 1'b0;

    typedef struct packed {
        logic load;
        logic mem_rd;
        logic div_start;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_status;

    function automatic logic uses_register(input logic [7:0] op);
        logic r;
        case (op) inside
            OP_AND, OP_LDR, OP_LDI, OP_STR, OP_OR, OP_XOR, OP_SUB, OP_ADD,
            OP_DIV, OP_MUL, OP_NOT, OP_JMPR, OP_BEQ, OP_BNE, OP_BGT, OP_BLT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/accumulator_cpu_instruction_execute_top.sv @@
// Top level of the accumulator machine execute block.
// Depends on acie_pkg, acie_ctrl, acie_dp, acie_div and the assertion macro header.
//
// Usage: each item on the slave stream is one decoded instruction (opcode and two
// operand bytes); each produces exactly one item on the master stream carrying the
// next PC, accumulator, carry and a status code. The APB port holds the start
// address register at byte address 0; writing it also loads the program counter.
// Each item is loaded, then the RAM is read (registered), then a divide runs in the
// bit-serial divider (eight steps), then the result is committed. A new item is
// taken only after the previous item has committed to the result registers.
// The block accepts a new item while its previous result still waits; if the
// receiver stalls, the next result is held back until the output register frees.
// Reset clears the architectural state and the controller (RAM entries read as zero
// through per-entry valid bits, so no clearing pass is needed) and sets the program counter to zero.
`include "accumulator_cpu_instruction_execute_top_assert.svh"

module accumulator_cpu_instruction_execute_top
    import acie_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] opcode, [15:8] first_operand, [23:16] second_operand
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] next_pc, [15:8] acc_value, [16] carry_flag, [19:17] status, [23:20] zero
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_ctrl_cmd         cmd;
    t_dp_status        dp_status;
    logic              cfg_we;
    logic [DATA_W-1:0] start_addr;
    logic [DATA_W-1:0] next_pc, acc_value;
    logic              carry_flag;
    logic [2:0]        status_code;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_START_ADDR);
    assign prdata = (paddr[2] == CFG_START_ADDR) ? {24'd0, start_addr} : 32'd0;

    acie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    acie_dp #(
        .REG_COUNT (REG_COUNT),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (s_axis_tdata[7:0]),
        .i_first       (s_axis_tdata[15:8]),
        .i_second      (s_axis_tdata[23:16]),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (pwdata[DATA_W-1:0]),
        .o_status      (dp_status),
        .o_start_addr  (start_addr),
        .o_next_pc     (next_pc),
        .o_acc_value   (acc_value),
        .o_carry_flag  (carry_flag),
        .o_status_code (status_code)
    );

    assign m_axis_tdata = {4'd0, status_code, carry_flag, acc_value, next_pc};

    `ACIE_ASSERT_NOW(a_commit_free, cmd.commit, (!m_axis_tvalid || m_axis_tready), "result overwritten while waiting")
    `ACIE_ASSERT_NEXT(a_one_item, (s_axis_tvalid && s_axis_tready), !s_axis_tready, "second item taken while busy")
    `ACIE_ASSERT_NOW(a_div_gated, cmd.div_start, dp_status.need_div, "divider started without a valid divide")
    `ACIE_ASSERT_NEXT(a_commit_valid, cmd.commit, m_axis_tvalid, "commit did not raise the output valid")

endmodule

@@ rtl/acie_div.sv @@
// Restoring 8-bit divider, one quotient bit per cycle.
// Depends on acie_pkg for the data width and step count.
module acie_div
    import acie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIV_STEPS);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dsr;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // The borrow bit of the trial subtraction decides the quotient bit.
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_busy && (r_cnt == CW'(DIV_STEPS - 1));
    assign o_quotient = r_quo;

endmodule

@@ rtl/acie_dp.sv @@
// Datapath: architectural state, data RAM, decode, execute and result registers.
// Depends on acie_pkg and instantiates acie_div.
module acie_dp
    import acie_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_opcode,
    input  logic [DATA_W-1:0] i_first,
    input  logic [DATA_W-1:0] i_second,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_data,
    output t_dp_status        o_status,
    output logic [DATA_W-1:0] o_start_addr,
    output logic [DATA_W-1:0] o_next_pc,
    output logic [DATA_W-1:0] o_acc_value,
    output logic              o_carry_flag,
    output logic [2:0]        o_status_code
);

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [DATA_W-1:0] r_op, r_x, r_y;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_gpr [REG_COUNT];
    logic              r_carry;
    logic [DATA_W-1:0] r_pc;
    logic              r_halted;
    logic [DATA_W-1:0] r_start;
    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;
    logic [DATA_W-1:0] r_mem_q;
    logic              r_mem_hit;

    logic [DATA_W-1:0] n_acc, n_pc, n_gpr_data, n_mem_data;
    logic              n_carry, n_halted, n_gpr_we, n_mem_we, n_clear;
    logic [2:0]        n_status;

    logic              reg_ok, unknown_op, uses_reg, err_any, taken;
    logic [DATA_W-1:0] rv, mem_rdata, quotient;
    logic [AW-1:0]     mem_addr;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]   sum;
    logic              div_done;

    // Address wrap modulo the RAM depth by compare-and-subtract of shifted depths.
    function automatic logic [AW-1:0] wrap_addr(input logic [DATA_W-1:0] a);
        logic [DATA_W:0] v;
        v = {1'b0, a};
        for (int k = DATA_W - 1; k >= 0; k--) begin
            if ((MEM_DEPTH << k) < (1 << DATA_W)) begin
                if (v >= (DATA_W + 1)'(MEM_DEPTH << k)) begin
                    v = v - (DATA_W + 1)'(MEM_DEPTH << k);
                end
            end
        end
        return v[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_x  <= i_first;
            r_y  <= i_second;
        end
    end

    assign uses_reg   = uses_register(r_op);
    assign reg_ok     = (r_x < DATA_W'(REG_COUNT));
    assign unknown_op = (r_op == OP_RSVD) || (r_op > OP_HALT);

    always_comb begin
        rv = '0;
        if (reg_ok) begin
            rv = r_gpr[r_x[RW-1:0]];
        end
    end

    assign err_any = r_halted || unknown_op || (uses_reg && !reg_ok)
                   || ((r_op == OP_DIV) && (rv == '0));

    assign o_status.need_div = (r_op == OP_DIV) && !err_any;
    assign o_status.div_done = div_done;

    acie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_acc),
        .i_divisor  (rv),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign mem_addr  = wrap_addr(((r_op == OP_LDA) || (r_op == OP_STA)) ? r_x : r_y);
    assign mem_rdata = r_mem_hit ? r_mem_q : '0;
    assign prod      = {{DATA_W{1'b0}}, r_acc} * {{DATA_W{1'b0}}, rv};
    assign sum       = {1'b0, r_acc} + {1'b0, rv};

    always_comb begin
        n_acc      = r_acc;
        n_carry    = r_carry;
        n_pc       = r_pc;
        n_halted   = r_halted;
        n_status   = ST_OK;
        n_gpr_we   = 1'b0;
        n_gpr_data = '0;
        n_mem_we   = 1'b0;
        n_mem_data = '0;
        n_clear    = 1'b0;
        taken      = 1'b0;
        if (r_halted) begin
            n_status = ST_HALTED;
        end else if (unknown_op) begin
            n_status = ST_UNKNOWN;
        end else if (uses_reg && !reg_ok) begin
            n_status = ST_BADREG;
        end else if ((r_op == OP_DIV) && (rv == '0)) begin
            n_status = ST_DIVZERO;
        end else begin
            case (r_op) inside
                OP_NOP, OP_NOPA, OP_NOPB: n_pc = r_pc + 8'd1;
                OP_AND: begin n_acc = r_acc & rv; n_pc = r_pc + 8'd2; end
                OP_OR:  begin n_acc = r_acc | rv; n_pc = r_pc + 8'd2; end
                OP_XOR: begin n_acc = r_acc ^ rv; n_pc = r_pc + 8'd2; end
                OP_LDA: begin n_acc = mem_rdata; n_pc = r_pc + 8'd2; end
                OP_LDR: begin
                    n_gpr_we = 1'b1; n_gpr_data = mem_rdata; n_pc = r_pc + 8'd3;
                end
                OP_LDI: begin
                    n_gpr_we = 1'b1; n_gpr_data = r_y; n_pc = r_pc + 8'd3;
                end
                OP_STA: begin
                    n_mem_we = 1'b1; n_mem_data = r_acc; n_pc = r_pc + 8'd2;
                end
                OP_STR: begin
                    n_mem_we = 1'b1; n_mem_data = rv; n_pc = r_pc + 8'd3;
                end
                OP_SUB: begin
                    // Carry is sticky: arithmetic only ever sets it.
                    if (r_acc < rv) n_carry = 1'b1;
                    n_acc = r_acc - rv;
                    n_pc  = r_pc + 8'd2;
                end
                OP_ADD: begin
                    if (sum[DATA_W]) n_carry = 1'b1;
                    n_acc = sum[DATA_W-1:0];
                    n_pc  = r_pc + 8'd2;
                end
                OP_DIV: begin n_acc = quotient; n_pc = r_pc + 8'd2; end
                OP_MUL: begin
                    if (prod[2*DATA_W-1:DATA_W] != '0) n_carry = 1'b1;
                    n_acc = prod[DATA_W-1:0];
                    n_pc  = r_pc + 8'd2;
                end
                OP_NOT: begin
                    n_gpr_we = 1'b1; n_gpr_data = ~rv; n_pc = r_pc + 8'd2;
                end
                OP_JMPR: n_pc = rv;
                OP_JMP:  n_pc = r_x;
                OP_RST: begin
                    n_acc    = '0;
                    n_carry  = 1'b0;
                    n_halted = 1'b0;
                    n_pc     = '0;
                    n_clear  = 1'b1;
                end
                OP_BEQ, OP_BNE, OP_BGT, OP_BLT: begin
                    case (r_op)
                        OP_BEQ:  taken = (r_acc == rv);
                        OP_BNE:  taken = (r_acc != rv);
                        OP_BGT:  taken = (r_acc > rv);
                        default: taken = (r_acc < rv);
                    endcase
                    n_pc = taken ? r_y : r_pc + 8'd3;
                end
                OP_BC, OP_BNC: begin
                    taken = (r_op == OP_BC) ? r_carry : !r_carry;
                    n_pc  = taken ? r_x : r_pc + 8'd2;
                end
                OP_SETC: begin n_carry = 1'b1; n_pc = r_pc + 8'd1; end
                OP_CLRC: begin n_carry = 1'b0; n_pc = r_pc + 8'd1; end
                default: begin
                    n_halted = 1'b1;
                    n_status = ST_HALTED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_carry  <= 1'b0;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_start  <= '0;
            for (int i = 0; i < REG_COUNT; i++) r_gpr[i] <= '0;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_data;
            r_pc    <= i_cfg_data;
        end else if (i_cmd.commit) begin
            r_acc    <= n_acc;
            r_carry  <= n_carry;
            r_pc     <= n_pc;
            r_halted <= n_halted;
            if (n_clear) begin
                for (int i = 0; i < REG_COUNT; i++) r_gpr[i] <= '0;
            end else if (n_gpr_we) begin
                r_gpr[r_x[RW-1:0]] <= n_gpr_data;
            end
        end
    end

    // Entries never written since reset or a clear read as zero through the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (i_cmd.commit && n_clear) begin
            r_mem_vld <= '0;
        end else if (i_cmd.commit && n_mem_we) begin
            r_mem_vld[mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_mem_we) begin
            r_mem[mem_addr] <= n_mem_data;
        end
        if (i_cmd.mem_rd) begin
            r_mem_q   <= r_mem[mem_addr];
            r_mem_hit <= r_mem_vld[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_next_pc     <= n_pc;
            o_acc_value   <= n_acc;
            o_carry_flag  <= n_carry;
            o_status_code <= n_status;
        end
    end

    assign o_start_addr = r_start;

endmodule

@@ rtl/acie_ctrl.sv @@
// Controller: sequences operand read, optional division and commit per item.
// Depends on acie_pkg for the command and status structs.
module acie_ctrl
    import acie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                // A result still waiting downstream holds the commit back.
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
